// ===== design/cbm_pkg.sv =====
// Package for the cartridge bank mapper: command codes, address decode
// constants, reset values and the types shared by the mapper modules.
// No dependencies.
`default_nettype none

package cbm_pkg;

  localparam int unsigned WORK_RAM_DEPTH_DEFAULT = 8192;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Register window decode values.
  localparam logic [15:0] READ_MASK    = 16'h7700;
  localparam logic [15:0] WRITE_MASK   = 16'h7300;
  localparam logic [15:0] REG_ID       = 16'h5000;
  localparam logic [15:0] REG_SECURITY = 16'h5100;
  localparam logic [15:0] REG_PROT     = 16'h5500;
  localparam logic [15:0] REG_LOW      = 16'h5000;
  localparam logic [15:0] REG_FORCE    = 16'h5100;
  localparam logic [15:0] REG_HIGH     = 16'h5200;
  localparam logic [15:0] REG_SEC_WR   = 16'h5300;
  localparam logic [15:0] REG_STROBE   = 16'h5101;

  localparam logic [7:0] ID_VALUE     = 8'h04;
  localparam logic [7:0] FORCE_VALUE  = 8'h06;
  localparam logic [7:0] FORCED_BANK  = 8'h03;
  localparam logic [8:0] LINE_UPPER   = 9'd128;
  localparam logic [8:0] LINE_LOWER   = 9'd240;

  // Reset values of the mapper state.
  localparam logic [3:0] LOW_NIBBLE_RST  = 4'hF;
  localparam logic [3:0] HIGH_NIBBLE_RST = 4'h0;
  localparam logic [7:0] PRG_BANK_RST    = 8'h00;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] prg_bank;
    logic       chr_low_bank;
    logic       chr_high_bank;
  } result_t;

  function automatic logic in_reg_window(input logic [15:0] a);
    return a[15:12] == 4'h5;
  endfunction

  function automatic logic in_ram_window(input logic [15:0] a);
    return a[15:13] == 3'b011;
  endfunction

endpackage

`default_nettype wire

// ===== design/cbm_wram.sv =====
// Work RAM of the mapper: single-port synchronous memory, one access a cycle,
// registered read data. Depends on cbm_pkg for the default depth.
`default_nettype none

module cbm_wram #(
  parameter int unsigned DEPTH = cbm_pkg::WORK_RAM_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] index,
  input  wire logic [7:0]               wdata,
  output logic      [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[index] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[index];
    end
  end

endmodule

`default_nettype wire

// ===== design/cbm_regs.sv =====
// Mapper control state: bank nibbles, split mode, security byte, strobe and
// trigger flags, character bank selects, and the bus read decode.
// Depends on cbm_pkg.
`default_nettype none

module cbm_regs (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire cbm_pkg::item_t  item,
  input  wire logic [7:0]      ram_rdata,
  output cbm_pkg::result_t     result
);

  import cbm_pkg::*;

  logic [3:0] low_nibble, low_nibble_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       split_mode, split_mode_next;
  logic [7:0] prg_bank, prg_bank_next;
  logic [7:0] security, security_next;
  logic       trigger, trigger_next;
  logic       strobe_nz, strobe_nz_next;
  logic       chr_low, chr_low_next;
  logic       chr_high, chr_high_next;
  logic [7:0] read_data;
  logic       data_zero;

  assign data_zero = item.write_data == 8'h00;

  always_comb begin
    low_nibble_next  = low_nibble;
    high_nibble_next = high_nibble;
    split_mode_next  = split_mode;
    prg_bank_next    = prg_bank;
    security_next    = security;
    trigger_next     = trigger;
    strobe_nz_next   = strobe_nz;
    chr_low_next     = chr_low;
    chr_high_next    = chr_high;
    read_data        = 8'h00;

    unique case (item.cmd)
      CMD_READ: begin
        read_data = item.addr[15:8];
        if (in_reg_window(item.addr)) begin
          unique case (item.addr & READ_MASK)
            REG_ID:       read_data = ID_VALUE;
            REG_SECURITY: read_data = security;
            REG_PROT:     read_data = trigger ? security : 8'h00;
            default:      read_data = item.addr[15:8];
          endcase
        end else if (in_ram_window(item.addr)) begin
          read_data = ram_rdata;
        end
      end
      CMD_WRITE: begin
        if (item.addr == REG_STROBE) begin
          // A falling strobe (nonzero, then zero) flips the trigger.
          if (strobe_nz && data_zero) begin
            trigger_next = ~trigger;
          end
          strobe_nz_next = ~data_zero;
        end else if (in_reg_window(item.addr)) begin
          unique case (item.addr & WRITE_MASK)
            REG_LOW: begin
              low_nibble_next = item.write_data[3:0];
              split_mode_next = item.write_data[7];
              prg_bank_next   = {high_nibble, item.write_data[3:0]};
              if (!item.write_data[7]) begin
                chr_low_next  = 1'b0;
                chr_high_next = 1'b1;
              end
            end
            REG_FORCE: begin
              if (item.write_data == FORCE_VALUE) begin
                prg_bank_next = FORCED_BANK;
              end
            end
            REG_HIGH: begin
              high_nibble_next = item.write_data[3:0];
              prg_bank_next    = {item.write_data[3:0], low_nibble};
            end
            REG_SEC_WR: security_next = item.write_data;
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        if (split_mode) begin
          if (item.scanline == LINE_UPPER) begin
            chr_low_next  = 1'b1;
            chr_high_next = 1'b1;
          end else if (item.scanline == LINE_LOWER) begin
            chr_low_next  = 1'b0;
            chr_high_next = 1'b0;
          end
        end
      end
      CMD_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_nibble  <= LOW_NIBBLE_RST;
      high_nibble <= HIGH_NIBBLE_RST;
      split_mode  <= 1'b1;
      prg_bank    <= PRG_BANK_RST;
      security    <= 8'h00;
      trigger     <= 1'b0;
      strobe_nz   <= 1'b1;
      chr_low     <= 1'b0;
      chr_high    <= 1'b1;
    end else if (advance) begin
      low_nibble  <= low_nibble_next;
      high_nibble <= high_nibble_next;
      split_mode  <= split_mode_next;
      prg_bank    <= prg_bank_next;
      security    <= security_next;
      trigger     <= trigger_next;
      strobe_nz   <= strobe_nz_next;
      chr_low     <= chr_low_next;
      chr_high    <= chr_high_next;
    end
  end

  assign result.read_data     = read_data;
  assign result.prg_bank      = prg_bank_next;
  assign result.chr_low_bank  = chr_low_next;
  assign result.chr_high_bank = chr_high_next;

endmodule

`default_nettype wire

// ===== design/cartridge_bank_mapper_with_protection_unit.sv =====
// Cartridge bank mapper with copy protection: CPU bus reads and writes and
// scanline ticks come in on one channel, one result word goes out per item.
//
// Input channel: in_valid / in_stall with cmd, addr, write_data, scanline.
// A word is taken at a rising edge where in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with read_data, prg_bank and the two
// character-RAM bank selects; every input word gives exactly one output word.
// An accepted word is held in the input register and moves to the result
// register once that is free. The work RAM is accessed at the accept edge
// itself, and the decode and state update sit between the two registers.
// Throughput: one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the input
// register keeps the next one; in_stall rises only once both are full.
// Reset (rst, synchronous) empties both stages and loads the mapper state:
// program bank 0, low nibble 15, split mode on, character banks 0 and 1.
// The work RAM is not cleared; a read of a never-written byte is undefined.
`default_nettype none

module cartridge_bank_mapper_with_protection_unit #(
  parameter int unsigned WORK_RAM_DEPTH = cbm_pkg::WORK_RAM_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  write_data,
  input  wire logic [8:0]  scanline,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic [7:0]       prg_bank,
  output logic             chr_low_bank,
  output logic             chr_high_bank
);

  import cbm_pkg::*;

  localparam int unsigned RamAw = $clog2(WORK_RAM_DEPTH);

  logic    s1_valid;
  item_t   s1_item;
  logic    out_load;
  logic    advance;
  logic    accept;
  logic    ram_wr;
  logic    ram_rd;
  logic [7:0] ram_rdata;
  result_t result;

  assign out_load = !out_valid || !out_stall;
  assign advance  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign accept   = in_valid && !in_stall;

  // The RAM is touched at the accept edge straight from the ports, so items
  // reach it in order and a read sees every earlier write.
  assign ram_wr = accept && (cmd_t'(cmd) == CMD_WRITE) && in_ram_window(addr);
  assign ram_rd = accept && (cmd_t'(cmd) == CMD_READ) && in_ram_window(addr);

  cbm_wram #(
    .DEPTH (WORK_RAM_DEPTH)
  ) u_wram (
    .clk   (clk),
    .wr_en (ram_wr),
    .rd_en (ram_rd),
    .index (addr[RamAw-1:0]),
    .wdata (write_data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.cmd        <= cmd_t'(cmd);
      s1_item.addr       <= addr;
      s1_item.write_data <= write_data;
      s1_item.scanline   <= scanline;
    end
  end

  cbm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (s1_item),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data     <= result.read_data;
      prg_bank      <= result.prg_bank;
      chr_low_bank  <= result.chr_low_bank;
      chr_high_bank <= result.chr_high_bank;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the cartridge bank mapper: bus reads, bus writes and scanline
// ticks are pushed through the valid/stall channels and every result word is
// checked against an in-bench predictor. Depends on cbm_pkg and the top level.
module tb;
  import cbm_pkg::*;

  localparam int RANDOM_WORDS = 550;
  localparam int CYCLE_LIMIT  = 60000;
  localparam int DRAIN_AT     = 300;

  typedef struct {
    item_t word;
    bit    drain;
  } bus_word_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [15:0] addr = '0;
  logic [7:0]  write_data = '0;
  logic [8:0]  scanline = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic [7:0]  prg_bank;
  logic        chr_low_bank;
  logic        chr_high_bank;

  cartridge_bank_mapper_with_protection_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .addr          (addr),
    .write_data    (write_data),
    .scanline      (scanline),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .prg_bank      (prg_bank),
    .chr_low_bank  (chr_low_bank),
    .chr_high_bank (chr_high_bank)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus bookkeeping.
  bus_word_t   bus_words_q[$];
  bit          ram_written[WORK_RAM_DEPTH_DEFAULT];
  logic [15:0] ram_addrs[$];
  int          total_words = 0;
  int          n_reads = 0, n_writes = 0, n_ticks = 0, n_idle = 0;

  // The shared counters sent_cnt and checked_cnt are only updated with nonblocking
  // assignments, so every reader sees the value from before the edge; err_cnt is not.
  int          sent_cnt = 0;
  int          checked_cnt = 0;
  int          err_cnt = 0;

  // Predictor state.
  logic [3:0]  lo_nib, hi_nib;
  logic        split_on, trig, strobe_hi, chr_lo, chr_hi;
  logic [7:0]  prg_sel, sec_byte;
  logic [7:0]  wram[WORK_RAM_DEPTH_DEFAULT];
  result_t     mapper_results_q[$];

  task automatic add(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
                     input logic [8:0] l, input bit drain = 1'b0);
    bus_word_t bw;
    bw.word.cmd        = c;
    bw.word.addr       = a;
    bw.word.write_data = d;
    bw.word.scanline   = l;
    bw.drain           = drain;
    bus_words_q.push_back(bw);
    total_words++;
    case (c)
      CMD_READ:  n_reads++;
      CMD_WRITE: n_writes++;
      CMD_TICK:  n_ticks++;
      default:   n_idle++;
    endcase
    if (c == CMD_WRITE && a[15:13] == 3'b011 && !ram_written[a[12:0]]) begin
      ram_written[a[12:0]] = 1'b1;
      ram_addrs.push_back(a);
    end
  endtask

  function automatic result_t mapper_step(input item_t w);
    result_t     r;
    logic [15:0] a;
    logic [7:0]  d;
    a = w.addr;
    d = w.write_data;
    r = '0;
    if (w.cmd == CMD_READ) begin
      r.read_data = a[15:8];
      if (a[15:12] == 4'h5) begin
        case (a & READ_MASK)
          REG_ID:       r.read_data = ID_VALUE;
          REG_SECURITY: r.read_data = sec_byte;
          REG_PROT:     r.read_data = trig ? sec_byte : 8'h00;
          default: ;
        endcase
      end else if (a[15:13] == 3'b011) begin
        r.read_data = wram[a[12:0]];
      end
    end else if (w.cmd == CMD_WRITE) begin
      if (a[15:13] == 3'b011) begin
        wram[a[12:0]] = d;
      end else if (a == REG_STROBE) begin
        // The trigger flips only on a falling strobe.
        if (strobe_hi && d == 8'h00) trig = !trig;
        strobe_hi = (d != 8'h00);
      end else if (a[15:12] == 4'h5) begin
        case (a & WRITE_MASK)
          REG_LOW: begin
            lo_nib   = d[3:0];
            split_on = d[7];
            prg_sel  = {hi_nib, lo_nib};
            if (!split_on) begin
              chr_lo = 1'b0;
              chr_hi = 1'b1;
            end
          end
          REG_FORCE:  if (d == FORCE_VALUE) prg_sel = FORCED_BANK;
          REG_HIGH: begin
            hi_nib  = d[3:0];
            prg_sel = {hi_nib, lo_nib};
          end
          REG_SEC_WR: sec_byte = d;
          default: ;
        endcase
      end
    end else if (w.cmd == CMD_TICK && split_on) begin
      if (w.scanline == LINE_UPPER) begin
        chr_lo = 1'b1;
        chr_hi = 1'b1;
      end else if (w.scanline == LINE_LOWER) begin
        chr_lo = 1'b0;
        chr_hi = 1'b0;
      end
    end
    r.prg_bank      = prg_sel;
    r.chr_low_bank  = chr_lo;
    r.chr_high_bank = chr_hi;
    return r;
  endfunction

  // Driver: bursts of words with random gaps; a word marked drain waits
  // until every earlier result has been checked.
  always @(posedge clk) begin : drive
    logic      took;
    bus_word_t nxt;
    int        burst_left;
    int        gap_left;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) sent_cnt <= sent_cnt + 1;
      if (!(in_valid && !took)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bus_words_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (bus_words_q[0].drain && (sent_cnt + took) != checked_cnt) begin
          in_valid <= 1'b0;
        end else begin
          nxt = bus_words_q.pop_front();
          in_valid   <= 1'b1;
          cmd        <= nxt.word.cmd;
          addr       <= nxt.word.addr;
          write_data <= nxt.word.write_data;
          scanline   <= nxt.word.scanline;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stall pattern changes mode at random intervals, and once
  // it holds off long enough for the block to back up into its input.
  always @(posedge clk) begin : receive
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       phase;
    bit       hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      mode      = RX_FREE;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && checked_cnt >= 200) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:  out_stall <= (phase % 3 == 0);
        endcase
      end
    end
  end

  // Monitor: checks the result word leaving the block, then predicts for
  // the word entering it in the same cycle.
  always @(posedge clk) begin : monitor
    item_t   w;
    result_t exp_r;
    if (rst) begin
      mapper_results_q.delete();
      lo_nib    = LOW_NIBBLE_RST;
      hi_nib    = HIGH_NIBBLE_RST;
      prg_sel   = PRG_BANK_RST;
      split_on  = 1'b1;
      sec_byte  = 8'h00;
      trig      = 1'b0;
      strobe_hi = 1'b1;
      chr_lo    = 1'b0;
      chr_hi    = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        checked_cnt <= checked_cnt + 1;
        if (mapper_results_q.size() == 0) begin
          $error("result word arrived with no prediction pending");
          err_cnt++;
        end else begin
          exp_r = mapper_results_q.pop_front();
          if (read_data !== exp_r.read_data) begin
            $error("read_data: expected %02h, got %02h", exp_r.read_data, read_data);
            err_cnt++;
          end
          if (prg_bank !== exp_r.prg_bank) begin
            $error("prg_bank: expected %02h, got %02h", exp_r.prg_bank, prg_bank);
            err_cnt++;
          end
          if (chr_low_bank !== exp_r.chr_low_bank) begin
            $error("chr_low_bank: expected %0b, got %0b", exp_r.chr_low_bank, chr_low_bank);
            err_cnt++;
          end
          if (chr_high_bank !== exp_r.chr_high_bank) begin
            $error("chr_high_bank: expected %0b, got %0b",
                   exp_r.chr_high_bank, chr_high_bank);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        w.cmd        = cmd_t'(cmd);
        w.addr       = addr;
        w.write_data = write_data;
        w.scanline   = scanline;
        mapper_results_q.push_back(mapper_step(w));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int cycles;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words checked",
               cycles, checked_cnt, total_words);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int          n;
    int          pick;
    cmd_t        c;
    logic [15:0] a;
    logic [7:0]  d;
    logic [8:0]  l;

    // Directed: ID and protection reads, the strobe/trigger sequence, bank
    // writes including the forced bank, scanline switching with split mode
    // on and off, work RAM at both ends, the unused command, ignored writes.
    add(CMD_READ,  16'h5000, 8'h00, 9'd0);
    add(CMD_READ,  16'h5100, 8'h00, 9'd0);
    add(CMD_READ,  16'h5500, 8'h00, 9'd0);
    add(CMD_READ,  16'hFFFF, 8'h00, 9'd0);
    add(CMD_WRITE, 16'h5300, 8'hA5, 9'd0);
    add(CMD_READ,  16'h5D00, 8'h00, 9'd0);
    add(CMD_WRITE, REG_STROBE, 8'h00, 9'd0);
    add(CMD_READ,  16'h5500, 8'h00, 9'd0);
    add(CMD_WRITE, REG_STROBE, 8'h00, 9'd0);
    add(CMD_WRITE, REG_STROBE, 8'hFF, 9'd0);
    add(CMD_WRITE, 16'h5200, 8'hFF, 9'd0);
    add(CMD_WRITE, 16'h5100, FORCE_VALUE, 9'd0);
    add(CMD_WRITE, 16'h5100, 8'h07, 9'd0);
    add(CMD_TICK,  16'h0000, 8'h00, LINE_UPPER);
    add(CMD_TICK,  16'h0000, 8'h00, LINE_LOWER);
    add(CMD_TICK,  16'h0000, 8'h00, 9'd261);
    add(CMD_WRITE, 16'h5000, 8'h05, 9'd0);
    add(CMD_TICK,  16'h0000, 8'h00, LINE_UPPER);
    add(CMD_WRITE, 16'h5000, 8'h80, 9'd0);
    add(CMD_WRITE, 16'h6000, 8'h5A, 9'd0);
    add(CMD_WRITE, 16'h7FFF, 8'hC3, 9'd0);
    add(CMD_READ,  16'h6000, 8'h00, 9'd0);
    add(CMD_READ,  16'h7FFF, 8'h00, 9'd0);
    add(CMD_NONE,  16'h5300, 8'hFF, 9'd256);
    add(CMD_WRITE, 16'h8000, 8'h11, 9'd0);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      a = 16'($urandom);
      d = 8'($urandom);
      l = 9'($urandom_range(0, 261));
      if (pick < 35) begin
        c = CMD_WRITE;
        a[15:12] = 4'h5;
        case ($urandom_range(0, 5))
          0: begin
            // Strobe writes lean toward zero so the trigger keeps toggling.
            a = REG_STROBE;
            if ($urandom_range(0, 1)) d = 8'h00;
          end
          1: a[9:8] = 2'b00;
          2: begin
            a[9:8] = 2'b01;
            if ($urandom_range(0, 1)) d = FORCE_VALUE;
          end
          3: a[9:8] = 2'b10;
          4: a[9:8] = 2'b11;
          default: ;
        endcase
      end else if (pick < 50) begin
        c = CMD_WRITE;
        a[15:13] = 3'b011;
      end else if (pick < 75) begin
        c = CMD_READ;
        case ($urandom_range(0, 3))
          0: a[15:12] = 4'h5;
          1: begin
            a[15:12] = 4'h5;
            case ($urandom_range(0, 2))
              0:       a[10:8] = 3'b000;
              1:       a[10:8] = 3'b001;
              default: a[10:8] = 3'b101;
            endcase
          end
          2: if (ram_addrs.size() != 0)
               a = ram_addrs[$urandom_range(0, ram_addrs.size() - 1)];
             else
               a[15:12] = 4'h5;
          default: ;
        endcase
        // Never read a work RAM byte that has not been written.
        if (a[15:13] == 3'b011 && !ram_written[a[12:0]]) a[15] = 1'b1;
      end else if (pick < 92) begin
        c = CMD_TICK;
        if ($urandom_range(0, 1)) l = $urandom_range(0, 1) ? LINE_UPPER : LINE_LOWER;
      end else if (pick < 96) begin
        c = CMD_WRITE;
      end else begin
        c = CMD_NONE;
      end
      add(c, a, d, l, n == DRAIN_AT);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (sent_cnt != total_words) @(posedge clk);
    while (checked_cnt != sent_cnt) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d words: %0d reads, %0d writes, %0d scanline ticks, %0d unused commands.",
             total_words, n_reads, n_writes, n_ticks, n_idle);
    $display("Checked %0d result words, %0d work RAM bytes written, %0d mismatches.",
             checked_cnt, ram_addrs.size(), err_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cbm_pkg.sv
design/cbm_wram.sv
design/cbm_regs.sv
design/cartridge_bank_mapper_with_protection_unit.sv
test/tb.sv
